// File: rtl/frt_pkg.sv
// Shared types and constants of the fault record table.
package frt_pkg;

	localparam int CODE_W  = 32;
	localparam int COUNT_W = 16;
	localparam int STAMP_W = 32;

	typedef enum logic [1:0] {
		CMD_RAISE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_RESET_NONCRIT = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	// Contents of one fault record.
	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
		logic               active;
	} rec_t;

	// Search token that walks the row of cells.
	typedef struct packed {
		logic               valid;
		logic               found;
		logic               is_match;
		rec_t               rec;
		logic [STAMP_W-1:0] min_stamp;
	} tok_t;

	// Update broadcast from the controller to every cell.
	typedef struct packed {
		logic              en;
		logic              clear_nc;
		logic [CODE_W-1:0] crit_mask;
		rec_t              rec;
	} wr_t;

endpackage

// File: rtl/fault_record_table.sv
// Top level of the fault record table: controller, mask register and the row of record cells.
//
// Usage. A request is offered on command, fault_code and timestamp with start
// high; it is taken at a rising edge where start is high and busy is low. The
// block then keeps busy high while the request is processed. Commands raise a
// fault, clear a fault, drop the faults outside critical_mask, or query.
//
// The records sit in a row of RECORDS cells. A search token enters the first
// cell in the cycle after the request is taken and moves one cell per cycle,
// collecting the first record whose code matches, the first empty record and
// the record with the oldest time. When it leaves the last cell the controller
// updates the chosen record and the mask and registers the result.
//
// Result: when the token leaves the last cell the result is registered and done
// is high for exactly one cycle; busy falls in that same cycle, so a new request
// can be taken while done is high. Requests do not overlap: each one waits for
// the token of the last to walk the whole row.
//
// The receiver cannot stall: each result is shown for one cycle only. critical_mask is
// written through cfg_we and cfg_wdata, by the user only while the block is idle; the
// block does not enforce this. Reset clears the mask, critical_mask and every record.
module fault_record_table import frt_pkg::*; #(
	parameter int RECORDS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [CODE_W-1:0]  fault_code,
	input  logic [STAMP_W-1:0] timestamp,
	input  logic               cfg_we,
	input  logic [CODE_W-1:0]  cfg_wdata,
	output logic               done,
	output logic [CODE_W-1:0]  active_mask,
	output logic               has_fault,
	output logic [CODE_W-1:0]  record_code,
	output logic [COUNT_W-1:0] record_count,
	output logic [STAMP_W-1:0] record_time,
	output logic               record_active
);

	localparam int IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;

	// Request registers and control.
	logic               busy_q;
	logic               launch_q;
	logic               done_q;
	cmd_t               cmd_q;
	logic [CODE_W-1:0]  code_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [CODE_W-1:0]  crit_q;
	logic [CODE_W-1:0]  mask_q;
	rec_t               res_q;
	logic               has_fault_q;

	logic accept;
	assign accept = start && !busy_q;

	// Token chain through the cells.
	tok_t             tok   [RECORDS+1];
	logic [IDX_W-1:0] sel_idx [RECORDS+1];
	logic [IDX_W-1:0] min_idx [RECORDS+1];

	wr_t              wr;
	logic [IDX_W-1:0] wr_idx;

	// The oldest search starts from the largest time at index zero, so a row
	// of all-ones times still picks the first record.
	always_comb begin
		tok[0]           = '0;
		tok[0].valid     = launch_q;
		tok[0].min_stamp = '1;
	end
	assign sel_idx[0] = '0;
	assign min_idx[0] = '0;

	for (genvar g = 0; g < RECORDS; g++) begin : g_cell
		frt_cell #(
			.INDEX (g),
			.IDX_W (IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.code_i    (code_q),
			.tok_i     (tok[g]),
			.sel_idx_i (sel_idx[g]),
			.min_idx_i (min_idx[g]),
			.tok_o     (tok[g+1]),
			.sel_idx_o (sel_idx[g+1]),
			.min_idx_o (min_idx[g+1]),
			.wr_i      (wr),
			.wr_idx_i  (wr_idx)
		);
	end

	// Finish step, taken when the token leaves the last cell.
	tok_t              tail;
	logic              finish;
	logic [CODE_W-1:0] mask_next;
	rec_t              res_next;
	rec_t              bumped;

	assign tail   = tok[RECORDS];
	assign finish = tail.valid;

	always_comb begin
		bumped        = tail.rec;
		bumped.code   = code_q;
		bumped.count  = (tail.rec.count == '1) ? tail.rec.count : tail.rec.count + 1'b1;
		bumped.stamp  = stamp_q;
		bumped.active = 1'b1;
	end

	always_comb begin
		wr           = '0;
		wr.crit_mask = crit_q;
		wr_idx       = sel_idx[RECORDS];
		mask_next    = mask_q;
		res_next     = tail.found ? tail.rec : '0;
		case (cmd_q)
			CMD_RAISE: begin
				mask_next = mask_q | code_q;
				wr.en     = finish;
				if (tail.found) begin
					wr.rec = bumped;
				end else begin
					// Table full and no match: the oldest record is replaced.
					wr_idx        = min_idx[RECORDS];
					wr.rec.code   = code_q;
					wr.rec.count  = COUNT_W'(1);
					wr.rec.stamp  = stamp_q;
					wr.rec.active = 1'b1;
				end
				res_next = wr.rec;
			end
			CMD_CLEAR: begin
				mask_next = mask_q & ~code_q;
				wr.en     = finish && tail.found;
				wr.rec    = tail.rec;
				wr.rec.active = 1'b0;
				if (tail.found) begin
					res_next.active = 1'b0;
				end
			end
			CMD_RESET_NONCRIT: begin
				mask_next   = mask_q & crit_q;
				wr.clear_nc = finish;
				if (tail.found && (tail.rec.code != '0) && ((tail.rec.code & crit_q) == '0)) begin
					res_next.active = 1'b0;
				end
			end
			default: begin
				// Query leaves the state alone.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			mask_q   <= '0;
			crit_q   <= '0;
		end else begin
			launch_q <= accept;
			done_q   <= finish;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				mask_q <= mask_next;
			end
			if (cfg_we) begin
				crit_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(command);
			code_q  <= fault_code;
			stamp_q <= timestamp;
		end
		if (finish) begin
			res_q       <= res_next;
			has_fault_q <= |(mask_next & code_q);
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign active_mask   = mask_q;
	assign has_fault     = has_fault_q;
	assign record_code   = res_q.code;
	assign record_count  = res_q.count;
	assign record_time   = res_q.stamp;
	assign record_active = res_q.active;

endmodule

// File: rtl/frt_cell.sv
// One record cell: holds a fault record and advances the search token by one place.
module frt_cell import frt_pkg::*; #(
	parameter int INDEX = 0,
	parameter int IDX_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CODE_W-1:0] code_i,
	input  tok_t              tok_i,
	input  logic [IDX_W-1:0]  sel_idx_i,
	input  logic [IDX_W-1:0]  min_idx_i,
	output tok_t              tok_o,
	output logic [IDX_W-1:0]  sel_idx_o,
	output logic [IDX_W-1:0]  min_idx_o,
	input  wr_t               wr_i,
	input  logic [IDX_W-1:0]  wr_idx_i
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	rec_t             rec_q;
	tok_t             tok_q;
	logic [IDX_W-1:0] sel_idx_q;
	logic [IDX_W-1:0] min_idx_q;

	logic hit;
	logic empty;
	logic take;
	logic older;

	assign hit   = (rec_q.code == code_i);
	assign empty = (rec_q.code == '0);
	// A matching code beats an earlier empty record; the first of each kind wins.
	assign take  = (hit && !tok_i.is_match) || (empty && !tok_i.found);
	assign older = (rec_q.stamp < tok_i.min_stamp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q     <= '0;
			sel_idx_q <= '0;
			min_idx_q <= '0;
		end else begin
			tok_q.valid     <= tok_i.valid;
			tok_q.found     <= tok_i.found | hit | empty;
			tok_q.is_match  <= tok_i.is_match | hit;
			tok_q.rec       <= take ? rec_q : tok_i.rec;
			tok_q.min_stamp <= older ? rec_q.stamp : tok_i.min_stamp;
			sel_idx_q       <= take ? MY_IDX : sel_idx_i;
			min_idx_q       <= older ? MY_IDX : min_idx_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (wr_i.en && (wr_idx_i == MY_IDX)) begin
			rec_q <= wr_i.rec;
		end else if (wr_i.clear_nc && !empty && ((rec_q.code & wr_i.crit_mask) == '0)) begin
			rec_q.active <= 1'b0;
		end
	end

	assign tok_o     = tok_q;
	assign sel_idx_o = sel_idx_q;
	assign min_idx_o = min_idx_q;

endmodule

// File: rtl/frt_checker.sv
// Port-level checks of the fault record table and their binding to the top level.
module frt_checker #(
	parameter int RECORDS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	logic accept;
	assign accept = start && !busy;

	// Every request gets its result after the token has crossed the row.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(RECORDS + 2) done)
		else $error("result not delivered at the expected cycle");

	// A taken request holds the block busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("busy not raised after a request");

	// The result strobe lasts one cycle and comes with the block free.
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("result strobe malformed");

	// No result without a request in flight.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !done |=> !done)
		else $error("result without a request");

endmodule

bind fault_record_table frt_checker #(.RECORDS(RECORDS)) u_frt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// File: dv/tb.sv
// Self-checking testbench of the fault record table: directed table and random phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import frt_pkg::*;

	localparam int RECORDS = 8;
	// At least the time from a request to its result, waited out once more at the end.
	localparam int LATENCY = RECORDS + 2;
	// The slowest correct run is about 775 requests, each with the longest gap
	// plus a full search; the limit below is several times that.
	localparam int LIMIT_CYCLES = 300_000;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 150;
	localparam int POOL_SIZE = 12;
	localparam int REPORT_MAX = 10;
	localparam int DIR_ROWS = 25;

	// One result as the block reports it.
	typedef struct packed {
		logic [CODE_W-1:0] mask;
		logic              hit;
		rec_t              rec;
	} outcome_t;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	// One row of the directed table. A configuration row carries the new
	// critical mask in its code field.
	typedef struct packed {
		row_kind_t          kind;
		cmd_t               cmd;
		logic [CODE_W-1:0]  code;
		logic [STAMP_W-1:0] stamp;
		logic               fixed_want;
		outcome_t           want;
	} row_t;

	// The directed part. Right after reset every record is empty, so a query
	// of any code reports an all-zero record; those rows carry their expected
	// result directly, and the rest are checked against the predictor.
	localparam row_t DIRECTED_ROWS [DIR_ROWS] = '{
		'{ROW_REQ, CMD_QUERY,         32'h0000_0000, 32'h0000_0000, 1'b1, '0},
		'{ROW_REQ, CMD_QUERY,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0},
		// Raising code zero lands in the first empty record, whose code stays zero.
		'{ROW_REQ, CMD_RAISE,         32'h0000_0000, 32'h0000_0064, 1'b0, '0},
		'{ROW_REQ, CMD_QUERY,         32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		// An unknown code reuses that same empty record and bumps its count.
		'{ROW_REQ, CMD_RAISE,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_REQ, CMD_RAISE,         32'h0000_0001, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, CMD_RAISE,         32'h0000_0002, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, CMD_RAISE,         32'h0000_0004, 32'h0000_0007, 1'b0, '0},
		'{ROW_REQ, CMD_RAISE,         32'h0000_0008, 32'h0000_0007, 1'b0, '0},
		'{ROW_REQ, CMD_RAISE,         32'h0000_0010, 32'h0000_0003, 1'b0, '0},
		'{ROW_REQ, CMD_RAISE,         32'h0000_0020, 32'h0000_0009, 1'b0, '0},
		'{ROW_REQ, CMD_RAISE,         32'h0000_0040, 32'h0000_0009, 1'b0, '0},
		// The table is full now: a query of a new code finds no record at all.
		'{ROW_REQ, CMD_QUERY,         32'h0000_0080, 32'h0000_0000, 1'b0, '0},
		// Raising it evicts the oldest record, the lower index of two equal times.
		'{ROW_REQ, CMD_RAISE,         32'h0000_0080, 32'h0000_0032, 1'b0, '0},
		'{ROW_REQ, CMD_RAISE,         32'h0000_0002, 32'h0000_003C, 1'b0, '0},
		'{ROW_REQ, CMD_CLEAR,         32'h0000_0002, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, CMD_CLEAR,         32'h0000_0100, 32'h0000_0000, 1'b0, '0},
		'{ROW_CFG, CMD_QUERY,         32'h0000_000F, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, CMD_RESET_NONCRIT, 32'h0000_0004, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, CMD_QUERY,         32'h0000_0010, 32'h0000_0000, 1'b0, '0},
		'{ROW_CFG, CMD_QUERY,         32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, CMD_RESET_NONCRIT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ROW_CFG, CMD_QUERY,         32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, CMD_RESET_NONCRIT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, CMD_QUERY,         32'h0000_0080, 32'h0000_0000, 1'b0, '0}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         command = CMD_QUERY;
	logic [CODE_W-1:0]  fault_code = '0;
	logic [STAMP_W-1:0] timestamp = '0;
	logic               cfg_we = 1'b0;
	logic [CODE_W-1:0]  cfg_wdata = '0;
	logic               done;
	logic [CODE_W-1:0]  active_mask;
	logic               has_fault;
	logic [CODE_W-1:0]  record_code;
	logic [COUNT_W-1:0] record_count;
	logic [STAMP_W-1:0] record_time;
	logic               record_active;

	fault_record_table #(
		.RECORDS(RECORDS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.fault_code   (fault_code),
		.timestamp    (timestamp),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.active_mask  (active_mask),
		.has_fault    (has_fault),
		.record_code  (record_code),
		.record_count (record_count),
		.record_time  (record_time),
		.record_active(record_active)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Our own copy of the block's state, advanced once per accepted request.
	logic [CODE_W-1:0] model_crit = '0;
	logic [CODE_W-1:0] model_faults = '0;
	rec_t              model_recs [RECORDS];

	// Results still to come from the block, oldest first.
	outcome_t pending_outcomes [$];
	int       fail_count = 0;
	int       results_seen = 0;

	// A record with a matching code wins; otherwise the first empty one, where
	// empty means code zero; otherwise there is none.
	function automatic int find_record(input logic [CODE_W-1:0] code);
		for (int i = 0; i < RECORDS; i++) begin
			if (model_recs[i].code == code) begin
				return i;
			end
		end
		for (int i = 0; i < RECORDS; i++) begin
			if (model_recs[i].code == '0) begin
				return i;
			end
		end
		return -1;
	endfunction

	// The record with the smallest time, lowest index on a tie. When every time
	// is all ones, the strict compare never fires and record zero is chosen.
	function automatic int oldest_record();
		logic [STAMP_W-1:0] best;
		int                 pick;
		best = '1;
		pick = 0;
		for (int i = 0; i < RECORDS; i++) begin
			if (model_recs[i].stamp < best) begin
				best = model_recs[i].stamp;
				pick = i;
			end
		end
		return pick;
	endfunction

	// Applies one request to the state copy and returns the result it causes.
	function automatic outcome_t apply_request(input cmd_t cmd, input logic [CODE_W-1:0] code,
			input logic [STAMP_W-1:0] stamp);
		int       slot;
		outcome_t res;
		case (cmd)
			CMD_RAISE: begin
				model_faults = model_faults | code;
				slot = find_record(code);
				if (slot >= 0) begin
					model_recs[slot].code = code;
					if (model_recs[slot].count != '1) begin
						model_recs[slot].count = model_recs[slot].count + 1'b1;
					end
				end else begin
					slot = oldest_record();
					model_recs[slot].code = code;
					model_recs[slot].count = COUNT_W'(1);
				end
				model_recs[slot].stamp = stamp;
				model_recs[slot].active = 1'b1;
			end
			CMD_CLEAR: begin
				model_faults = model_faults & ~code;
				slot = find_record(code);
				if (slot >= 0) begin
					model_recs[slot].active = 1'b0;
				end
			end
			CMD_RESET_NONCRIT: begin
				model_faults = model_faults & model_crit;
				for (int i = 0; i < RECORDS; i++) begin
					if (model_recs[i].code != '0 && (model_recs[i].code & model_crit) == '0) begin
						model_recs[i].active = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		res.mask = model_faults;
		res.hit = |(model_faults & code);
		slot = find_record(code);
		res.rec = (slot >= 0) ? model_recs[slot] : '0;
		return res;
	endfunction

	// Idle cycles before a request: half of them back to back, most others short
	// enough to land on each cycle of the block's search, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 12);
		end
		return $urandom_range(13, 60);
	endfunction

	task automatic report_mismatch(input string what, input outcome_t want, input outcome_t got);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("%s at result %0d", what, results_seen);
			$display("  expected mask %h hit %b code %h count %h time %h active %b",
				want.mask, want.hit, want.rec.code, want.rec.count, want.rec.stamp, want.rec.active);
			$display("  actual   mask %h hit %b code %h count %h time %h active %b",
				got.mask, got.hit, got.rec.code, got.rec.count, got.rec.stamp, got.rec.active);
		end
	endtask

	// Offers one request after the given number of idle cycles and returns at
	// the edge that takes it, with its expected result queued. When the gap is
	// zero, start stays high from the previous request and only the fields move.
	task automatic issue(input cmd_t cmd, input logic [CODE_W-1:0] code,
			input logic [STAMP_W-1:0] stamp, input int gap, input logic fixed_want,
			input outcome_t want);
		outcome_t pred;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		fault_code <= code;
		timestamp <= stamp;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pred = apply_request(cmd, code, stamp);
		pending_outcomes.push_back(fixed_want ? want : pred);
	endtask

	// Stops offering requests and waits until every result has come back.
	task automatic drain();
		start <= 1'b0;
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// The critical mask is only written with the block idle.
	task automatic write_critical(input logic [CODE_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_crit = value;
	endtask

	// Results are shown for one cycle only, so each strobe is taken as it comes
	// and checked field by field against the oldest expectation.
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && done) begin
			got.mask = active_mask;
			got.hit = has_fault;
			got.rec.code = record_code;
			got.rec.count = record_count;
			got.rec.stamp = record_time;
			got.rec.active = record_active;
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with no request pending", '0, got);
			end else begin
				want = pending_outcomes.pop_front();
				if (got.mask !== want.mask || got.hit !== want.hit
						|| got.rec.code !== want.rec.code || got.rec.count !== want.rec.count
						|| got.rec.stamp !== want.rec.stamp || got.rec.active !== want.rec.active) begin
					report_mismatch("mismatch", want, got);
				end
			end
		end
	end

	// Watchdog: a lost result or a stuck busy ends the run here.
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** fault_record_table: FAILED **");
		$finish;
	end

	initial begin
		logic [CODE_W-1:0]  code_pool [POOL_SIZE];
		logic [CODE_W-1:0]  crit;
		logic [CODE_W-1:0]  code;
		logic [STAMP_W-1:0] now_ms;
		cmd_t               cmd;
		int                 roll;

		for (int i = 0; i < RECORDS; i++) begin
			model_recs[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, walked row by row.
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
				write_critical(DIRECTED_ROWS[r].code);
			end else begin
				issue(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].stamp,
					pick_gap(), DIRECTED_ROWS[r].fixed_want, DIRECTED_ROWS[r].want);
			end
		end

		// Random phases. Each phase draws a fresh pool of codes, a few more than
		// there are records so that hits, empty slots and evictions all occur,
		// and sets a new critical mask: none, all, then mixed values.
		now_ms = 32'd100_000;
		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				if (i < POOL_SIZE / 2) begin
					code_pool[i] = 32'h1 << $urandom_range(0, CODE_W - 1);
				end else begin
					code_pool[i] = $urandom;
				end
			end
			case (p)
				0: crit = '0;
				1: crit = '1;
				3: crit = code_pool[$urandom_range(0, POOL_SIZE - 1)]
					| code_pool[$urandom_range(0, POOL_SIZE - 1)];
				default: crit = $urandom;
			endcase
			write_critical(crit);

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 42) begin
					cmd = CMD_RAISE;
				end else if (roll < 62) begin
					cmd = CMD_CLEAR;
				end else if (roll < 93) begin
					cmd = CMD_QUERY;
				end else begin
					cmd = CMD_RESET_NONCRIT;
				end

				// Mostly pool codes, so records are revisited; some noise besides.
				roll = $urandom_range(0, 99);
				if (roll < 72) begin
					code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
				end else if (roll < 82) begin
					code = $urandom;
				end else if (roll < 87) begin
					code = '0;
				end else if (roll < 94) begin
					code = code_pool[$urandom_range(0, POOL_SIZE - 1)]
						| code_pool[$urandom_range(0, POOL_SIZE - 1)];
				end else begin
					code = ~code_pool[$urandom_range(0, POOL_SIZE - 1)];
				end

				// Time mostly creeps forward with frequent ties, sometimes jumps.
				roll = $urandom_range(0, 99);
				if (roll < 90) begin
					now_ms = now_ms + $urandom_range(0, 3);
				end else if (roll < 95) begin
					now_ms = $urandom;
				end else if (roll < 98) begin
					now_ms = '0;
				end else begin
					now_ms = '1;
				end

				issue(cmd, code, now_ms, pick_gap(), 1'b0, '0);
			end
		end

		drain();
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0 && pending_outcomes.size() == 0) begin
			$display("** fault_record_table: PASSED **");
		end else begin
			$display("** fault_record_table: FAILED **");
		end
		$finish;
	end

endmodule

// File: fault_record_table.f
rtl/frt_pkg.sv
rtl/frt_cell.sv
rtl/fault_record_table.sv
rtl/frt_checker.sv
dv/tb.sv
